// ----- hw/rtl/u8tx_pkg.sv -----
// ----------------------------------------------------------------------------
// u8tx_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8tx_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [20:0] CODE_MAX     = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] MIN_LEN3     = 21'h000800;
    localparam logic [20:0] MIN_LEN2     = 21'h000080;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] BOM_CODE     = 21'h00FEFF;
    localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

    localparam logic [2:0]  SEQ_LEN0     = 3'd0;
    localparam logic [2:0]  SEQ_LEN2     = 3'd2;
    localparam logic [2:0]  SEQ_LEN3     = 3'd3;
    localparam logic [2:0]  SEQ_LEN4     = 3'd4;

    localparam int          QUEUE_DEPTH  = 4;
    localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [15:0] unit;
        logic        unit_valid;
        logic        replaced;
        logic        run_last;
        logic        string_end;
    } result_t;

    typedef struct packed {
        result_t     res1;
        result_t     res0;
        logic [1:0]  count;
    } dec_out_t;

    function automatic result_t make_unit(input logic [15:0] u, input logic rep);
        result_t r;
        r.unit       = u;
        r.unit_valid = 1'b1;
        r.replaced   = rep;
        r.run_last   = 1'b0;
        r.string_end = 1'b0;
        return r;
    endfunction

endpackage

// ----- hw/rtl/u8tx_decode.sv -----
// ----------------------------------------------------------------------------
// u8tx_decode
// Sequence state and single-pass decode of one UTF-8 byte into up to two
// UTF-16 result words.
// ----------------------------------------------------------------------------
module u8tx_decode
    import u8tx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output dec_out_t   dec
);

    logic [1:0]  pend_reg,     pend_next;
    logic [2:0]  slen_reg,     slen_next;
    logic [20:0] acc_reg,      acc_next;
    logic        at_start_reg;
    logic        began_reg,    began_next;

    logic        cont;
    logic        fin;
    logic        fin_bad;
    logic        is_bom;
    logic        do_begin;
    logic        begin_first;
    logic [20:0] acc_shift;
    logic [20:0] supp;
    logic [1:0]  n;
    result_t     res [2];

    assign cont      = (in_byte[7:6] == 2'b10);
    assign acc_shift = {acc_reg[14:0], in_byte[5:0]};
    assign supp      = acc_shift - SUPP_BASE;

    always_comb
    begin
        unique case (slen_reg)
            SEQ_LEN4: fin_bad = (acc_shift < SUPP_BASE) || (acc_shift > CODE_MAX);
            SEQ_LEN3: fin_bad = (acc_shift < MIN_LEN3);
            default:  fin_bad = (acc_shift < MIN_LEN2);
        endcase
        if (acc_shift >= SURR_FIRST && acc_shift <= SURR_LAST)
        begin
            fin_bad = 1'b1;
        end
    end

    assign is_bom = (slen_reg == SEQ_LEN3) && (acc_shift == BOM_CODE) && began_reg;

    always_comb
    begin
        pend_next   = pend_reg;
        slen_next   = slen_reg;
        acc_next    = acc_reg;
        began_next  = began_reg;
        n           = 2'd0;
        res[0]      = '0;
        res[1]      = '0;
        fin         = 1'b0;
        do_begin    = 1'b0;
        begin_first = 1'b0;

        if (pend_reg != 2'd0)
        begin
            if (cont)
            begin
                acc_next  = acc_shift;
                pend_next = pend_reg - 2'd1;
                fin       = (pend_reg == 2'd1);
            end
            else
            begin
                res[n[0]] = make_unit(REPL_UNIT, 1'b1);
                n         = n + 2'd1;
                pend_next = 2'd0;
                do_begin  = 1'b1;
            end
        end
        else
        begin
            do_begin    = 1'b1;
            begin_first = at_start_reg;
        end

        if (fin)
        begin
            if (fin_bad)
            begin
                res[n[0]] = make_unit(REPL_UNIT, 1'b1);
                n         = n + 2'd1;
            end
            else if (!is_bom)
            begin
                if (acc_shift[20:16] != 5'd0)
                begin
                    res[0] = make_unit({HI_SURR_TAG, supp[19:10]}, 1'b0);
                    res[1] = make_unit({LO_SURR_TAG, supp[9:0]}, 1'b0);
                    n      = 2'd2;
                end
                else
                begin
                    res[n[0]] = make_unit(acc_shift[15:0], 1'b0);
                    n         = n + 2'd1;
                end
            end
        end

        if (do_begin)
        begin
            if (!in_byte[7])
            begin
                res[n[0]] = make_unit({8'h00, in_byte}, 1'b0);
                n         = n + 2'd1;
            end
            else if (cont)
            begin
                // drop stray continuation
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                acc_next   = {18'd0, in_byte[2:0]};
                slen_next  = SEQ_LEN4;
                pend_next  = 2'd3;
                began_next = begin_first;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                acc_next   = {17'd0, in_byte[3:0]};
                slen_next  = SEQ_LEN3;
                pend_next  = 2'd2;
                began_next = begin_first;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                acc_next   = {16'd0, in_byte[4:0]};
                slen_next  = SEQ_LEN2;
                pend_next  = 2'd1;
                began_next = begin_first;
            end
            else
            begin
                res[n[0]] = make_unit(REPL_UNIT, 1'b1);
                n         = n + 2'd1;
            end
        end

        if (in_last)
        begin
            if (pend_next != 2'd0 && n != 2'd2)
            begin
                res[n[0]] = make_unit(REPL_UNIT, 1'b1);
                n         = n + 2'd1;
            end
            if (n == 2'd0)
            begin
                res[0] = '0;
                n      = 2'd1;
            end
            pend_next  = 2'd0;
            slen_next  = SEQ_LEN0;
            acc_next   = '0;
            began_next = 1'b0;
        end

        if (n == 2'd2)
        begin
            res[1].run_last   = 1'b1;
            res[1].string_end = in_last;
        end
        else if (n == 2'd1)
        begin
            res[0].run_last   = 1'b1;
            res[0].string_end = in_last;
        end
    end

    assign dec.res0  = res[0];
    assign dec.res1  = res[1];
    assign dec.count = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 2'd0;
            slen_reg     <= SEQ_LEN0;
            acc_reg      <= '0;
            at_start_reg <= 1'b1;
            began_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg     <= pend_next;
            slen_reg     <= slen_next;
            acc_reg      <= acc_next;
            at_start_reg <= in_last;
            began_reg    <= began_next;
        end
    end

endmodule

// ----- hw/rtl/utf8_to_utf16_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, one word per handshake.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle while s_tready is high, with
// s_tlast on the final byte of a string, and gives each decoded code point as
// one UTF-16 word or as a surrogate pair, high half first. Malformed input
// gives U+FFFD with the replaced flag set; a leading U+FEFF is dropped. A
// string's final byte that yields no unit gives one end marker word with
// unit_valid low. Each byte is decoded in the cycle it is accepted and its
// words are written into a four-entry result queue that the master side
// reads. Input ready stays high while two or fewer words are queued: bytes
// that give one word or none stream at one byte per cycle while m_tready is
// high, and the queue absorbs the two output handshakes of a two-word byte.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
    import u8tx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] unit
    output logic [2:0]  m_tuser,   // [0] unit_valid, [1] replaced, [2] run_last
    output logic        m_tlast    // string_end
);

    logic                accept;
    logic                pop;
    dec_out_t            dec;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg,  count_next;
    logic [QPTR_W:0]     push_cnt;
    logic [QPTR_W-1:0]   wr_ptr_inc;
    result_t             queue_reg [QUEUE_DEPTH];
    result_t             head;

    assign s_tready = (count_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    u8tx_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .dec     (dec)
    );

    assign push_cnt    = accept ? {{(QPTR_W-1){1'b0}}, dec.count} : '0;
    assign wr_ptr_inc  = wr_ptr_reg + {{(QPTR_W-1){1'b0}}, 1'b1};
    assign wr_ptr_next = wr_ptr_reg + push_cnt[QPTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + {{(QPTR_W-1){1'b0}}, pop};
    assign count_next  = count_reg + push_cnt - {{QPTR_W{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (accept && dec.count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= dec.res0;
        end
        if (accept && dec.count == 2'd2)
        begin
            queue_reg[wr_ptr_inc] <= dec.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = head.unit;
    assign m_tuser = {head.run_last, head.replaced, head.unit_valid};
    assign m_tlast = head.string_end;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking stream testbench for utf8_to_utf16_transcoder.
// ----------------------------------------------------------------------------
// A queue of UTF-8 bytes feeds a clocked driver on the slave side. Each
// accepted byte runs through a local decoder that keeps its own sequence
// state and queues the UTF-16 words it expects. A clocked monitor on the
// master side compares every accepted word field by field with the oldest
// expected word. The stimulus starts with hand-picked strings that cover
// code point limits, malformed forms, a byte order mark, truncation and a
// bare end marker. It then runs random strings, mostly well-formed sequences
// with random content mixed with broken ones, under three patterns of
// idling on the two sides.
// ----------------------------------------------------------------------------
module tb;
    import u8tx_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    byte_item_t  byte_queue[$];
    byte_item_t  next_item;
    logic [7:0]  string_bytes[$];
    result_t     expected_words[$];
    result_t     step_words[$];
    result_t     got_word;
    result_t     want_word;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;
    int          bytes_queued = 0;

    logic [1:0]  cont_left = 2'd0;
    logic [2:0]  seq_len = SEQ_LEN0;
    logic [20:0] code_acc = 21'd0;
    logic        string_start = 1'b1;
    logic        seq_from_start = 1'b0;

    utf8_to_utf16_transcoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    task automatic emit_unit(input logic [15:0] u, input logic rep);
        result_t r;
        if (step_words.size() < 2)
        begin
            r.unit       = u;
            r.unit_valid = 1'b1;
            r.replaced   = rep;
            r.run_last   = 1'b0;
            r.string_end = 1'b0;
            step_words.push_back(r);
        end
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        logic [20:0] off;
        if (cp < SUPP_BASE)
            emit_unit(cp[15:0], 1'b0);
        else
        begin
            off = cp - SUPP_BASE;
            emit_unit({HI_SURR_TAG, off[19:10]}, 1'b0);
            emit_unit({LO_SURR_TAG, off[9:0]}, 1'b0);
        end
    endtask

    task automatic start_sequence(input logic [7:0] b, input logic first);
        if (b[7] == 1'b0)
            emit_unit({8'h00, b}, 1'b0);
        else if (b[7:3] == 5'b11110)
        begin
            code_acc       = {18'd0, b[2:0]};
            seq_len        = SEQ_LEN4;
            cont_left      = 2'd3;
            seq_from_start = first;
        end
        else if (b[7:4] == 4'b1110)
        begin
            code_acc       = {17'd0, b[3:0]};
            seq_len        = SEQ_LEN3;
            cont_left      = 2'd2;
            seq_from_start = first;
        end
        else if (b[7:5] == 3'b110)
        begin
            code_acc       = {16'd0, b[4:0]};
            seq_len        = SEQ_LEN2;
            cont_left      = 2'd1;
            seq_from_start = first;
        end
        else if (b[7:6] != 2'b10)
            emit_unit(REPL_UNIT, 1'b1);
    endtask

    task automatic close_sequence();
        logic bad;
        case (seq_len)
            SEQ_LEN4: bad = (code_acc < SUPP_BASE) || (code_acc > CODE_MAX);
            SEQ_LEN3: bad = (code_acc < MIN_LEN3);
            default:  bad = (code_acc < MIN_LEN2);
        endcase
        bad = bad || (code_acc >= SURR_FIRST && code_acc <= SURR_LAST);
        if (bad)
            emit_unit(REPL_UNIT, 1'b1);
        else if (!(seq_len == SEQ_LEN3 && code_acc == BOM_CODE && seq_from_start))
            emit_code_point(code_acc);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic    first;
        result_t tail;
        first = string_start;
        step_words.delete();
        string_start = 1'b0;
        if (cont_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    close_sequence();
            end
            else
            begin
                emit_unit(REPL_UNIT, 1'b1);
                cont_left = 2'd0;
                start_sequence(b, 1'b0);
            end
        end
        else
            start_sequence(b, first);
        if (last)
        begin
            if (cont_left != 2'd0)
                emit_unit(REPL_UNIT, 1'b1);
            if (step_words.size() == 0)
            begin
                tail = '0;
                step_words.push_back(tail);
            end
            cont_left      = 2'd0;
            seq_len        = SEQ_LEN0;
            code_acc       = 21'd0;
            string_start   = 1'b1;
            seq_from_start = 1'b0;
        end
        if (step_words.size() != 0)
        begin
            tail = step_words[step_words.size() - 1];
            tail.run_last   = 1'b1;
            tail.string_end = last;
            step_words[step_words.size() - 1] = tail;
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endtask

    task automatic encode(input logic [20:0] cp, input int len);
        case (len)
            1: string_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                string_bytes.push_back({3'b110, cp[10:6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                string_bytes.push_back({4'b1110, cp[15:12]});
                string_bytes.push_back({2'b10, cp[11:6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                string_bytes.push_back({5'b11110, cp[20:18]});
                string_bytes.push_back({2'b10, cp[17:12]});
                string_bytes.push_back({2'b10, cp[11:6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic flush_string();
        byte_item_t w;
        foreach (string_bytes[i])
        begin
            w.data = string_bytes[i];
            w.last = (i == string_bytes.size() - 1);
            byte_queue.push_back(w);
            bytes_queued++;
        end
        string_bytes.delete();
    endtask

    task automatic add_segment(input logic first);
        int          pick;
        int          len;
        int          cut;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (first && $urandom_range(7) == 0)
            pick = 60;
        if (pick < 20)
            encode(21'($urandom_range(21'h7F, 0)), 1);
        else if (pick < 35)
            encode(21'($urandom_range(21'h7FF, 21'h80)), 2);
        else if (pick < 50)
            encode(21'($urandom_range(21'hFFFF, 21'h800)), 3);
        else if (pick < 60)
            encode(21'($urandom_range(21'h10FFFF, 21'h10000)), 4);
        else if (pick < 64)
            encode(BOM_CODE, 3);
        else if (pick < 69)
        begin
            len = $urandom_range(4, 2);
            if (len == 2)
                cp = 21'($urandom_range(21'h7F, 0));
            else if (len == 3)
                cp = 21'($urandom_range(21'h7FF, 0));
            else
                cp = 21'($urandom_range(21'hFFFF, 0));
            encode(cp, len);
        end
        else if (pick < 72)
            encode(21'($urandom_range(SURR_LAST, SURR_FIRST)), 3);
        else if (pick < 75)
            encode(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
        else if (pick < 80)
        begin
            len = $urandom_range(4, 2);
            if (len == 2)
                cp = 21'($urandom_range(21'h7FF, 21'h80));
            else if (len == 3)
                cp = 21'($urandom_range(21'hFFFF, 21'h800));
            else
                cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            encode(cp, len);
            cut = $urandom_range(len - 1, 1);
            repeat (cut)
                string_bytes.delete(string_bytes.size() - 1);
        end
        else if (pick < 84)
            string_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        else if (pick < 87)
            string_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
        else
            string_bytes.push_back(8'($urandom_range(8'hFF, 0)));
    endtask

    task automatic add_random_strings(input int count);
        int target;
        int segs;
        target = bytes_queued + count;
        while (bytes_queued < target)
        begin
            segs = $urandom_range(6, 1);
            for (int i = 0; i < segs; i++)
                add_segment(i == 0);
            flush_string();
        end
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tlast  <= next_item.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word = {m_tdata, m_tuser[0], m_tuser[1], m_tuser[2], m_tlast};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: unit %h valid %b repl %b run_last %b end %b",
                             got_word.unit, got_word.unit_valid, got_word.replaced,
                             got_word.run_last, got_word.string_end);
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (got_word !== want_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("word differs: expected unit %h valid %b repl %b %s",
                                 want_word.unit, want_word.unit_valid,
                                 want_word.replaced, "");
                        $display("  expected run_last %b end %b",
                                 want_word.run_last, want_word.string_end);
                        $display("  got unit %h valid %b repl %b run_last %b end %b",
                                 got_word.unit, got_word.unit_valid, got_word.replaced,
                                 got_word.run_last, got_word.string_end);
                    end
                end
            end
        end
    end

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("utf8_to_utf16_transcoder: mismatch");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 54;
        // BOM at string start, ASCII limits, 2-byte minimum, overlong 2-byte
        string_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'h7F, 8'hC2, 8'h80, 8'hC0, 8'hAF};
        flush_string();
        // 4-byte minimum, above range, surrogate, invalid lead, bad continuation,
        // truncated at end
        string_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                         8'hED, 8'hA0, 8'h80, 8'hF8, 8'hC2, 8'h41, 8'hE2, 8'h82};
        flush_string();
        // stray continuation alone: bare end marker
        string_bytes = '{8'h80};
        flush_string();
        add_random_strings(400);
        drain();

        send_idle_pct = 54;
        recv_idle_pct = 24;
        add_random_strings(400);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_strings(400);
        drain();

        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("utf8_to_utf16_transcoder: match");
        else
            $display("utf8_to_utf16_transcoder: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/u8tx_pkg.sv
hw/rtl/u8tx_decode.sv
hw/rtl/utf8_to_utf16_transcoder.sv
tb/tb.sv
